>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/mlwed_pkg.sv
// ----------------------------------------------------------------------------
// mlwed_pkg
// shared types and constants of the module-lwe decryption block
// ----------------------------------------------------------------------------
package mlwed_pkg;

   localparam int RING_DEGREE_DEFAULT = 256;
   localparam int MODULE_RANK_DEFAULT = 2;

   localparam int WORD_WIDTH      = 32;
   localparam int KEY_WIDTH       = 16;
   localparam int POSITION_WIDTH  = 10;
   localparam int MODULUS_WIDTH   = 17;
   localparam int INDEX_WIDTH     = 8;
   localparam int MESSAGE_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [1:0] MODE_LOAD_KEY    = 2'd0;
   localparam logic [1:0] MODE_LOAD_CIPHER = 2'd1;
   localparam logic [1:0] MODE_READ        = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLAINTEXT_MODULUS = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_DELTA       = 4'd1;

   localparam logic [MODULUS_WIDTH-1:0] MODULUS_DEFAULT = 17'd65536;
   localparam logic [WORD_WIDTH-1:0]    DELTA_DEFAULT   = 32'd65536;

   typedef struct packed {
      logic [1:0]                       mode;
      logic [POSITION_WIDTH-1:0]        position;
      logic signed [KEY_WIDTH-1:0]      key_coeff;
      logic [WORD_WIDTH-1:0]            cipher_word;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0]   coeff_index;
      logic [MESSAGE_WIDTH-1:0] message_coeff;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic negate;
   } mac_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_QUOT,
      ST_REM_START,
      ST_REM,
      ST_FINAL
   } state_type;

endpackage

>>> sv/module_lwe_decrypt.sv
// ----------------------------------------------------------------------------
// module_lwe_decrypt
// module-lwe decryption over Z_2^32[x]/(x^D+1) with an iterative datapath
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low. mode 0 writes a
// key coefficient, mode 1 a ciphertext word; both leave busy low. mode 2
// with a position below RING_DEGREE decodes one message coefficient;
// other reads and mode 3 are dropped without a result.
// a decode walks all MODULE_RANK*RING_DEGREE key and ciphertext pairs
// through one multiply-accumulate fed by one memory read port per store,
// then runs one shared 32-step divider twice, for the rounded quotient
// and for the reduction modulo p. busy stays high for the whole decode;
// the accumulate takes one key and ciphertext pair per cycle and the
// divider is bit-serial.
// the result shows on rsp_data with rsp_strobe, high for exactly one
// cycle, in the first cycle with busy low again; the next request can be
// taken in that cycle. the receiver cannot hold the result off.
// csr writes go through the csr channel, always ready; the user must write
// only while idle, the block itself does not enforce it. reset is
// synchronous and returns both registers to 65536; store contents are
// undefined until loaded and need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module module_lwe_decrypt #(
   parameter int RING_DEGREE = mlwed_pkg::RING_DEGREE_DEFAULT,
   parameter int MODULE_RANK = mlwed_pkg::MODULE_RANK_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  mlwed_pkg::req_type                        req_data,
   output logic                                      rsp_strobe,
   output mlwed_pkg::rsp_type                        rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mlwed_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [mlwed_pkg::WORD_WIDTH-1:0]          csr_data
);

   localparam int W         = mlwed_pkg::WORD_WIDTH;
   localparam int PW        = mlwed_pkg::MODULUS_WIDTH;
   localparam int KEY_DEPTH = MODULE_RANK * RING_DEGREE;
   localparam int CT_DEPTH  = (MODULE_RANK + 1) * RING_DEGREE;
   localparam int KEY_AW    = $clog2(KEY_DEPTH);
   localparam int CT_AW     = $clog2(CT_DEPTH);
   localparam int JW        = $clog2(RING_DEGREE);

   mlwed_pkg::state_type state_ff, state_in;

   logic [PW-1:0] modulus_ff;
   logic [W-1:0]  delta_ff;
   logic [PW-1:0] p_eff;
   logic [W-1:0]  delta_eff;

   logic [W-1:0]  pos_wide;
   logic          accept, key_we, ct_we, read_go;

   logic [JW-1:0]     i_ff, i_in;
   logic [JW-1:0]     j_ff, j_in;
   logic [KEY_AW-1:0] key_addr_ff, key_addr_in;
   logic [CT_AW-1:0]  row_base_ff, row_base_in;
   logic              drain_ff, drain_in;
   logic              rd_valid_ff, rd_neg_ff;
   logic [mlwed_pkg::INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic              neg_ff, neg_in;
   logic              issue, j_after_i;
   logic [JW:0]       i_minus_j;
   logic [JW-1:0]     ct_idx;
   logic [CT_AW-1:0]  ct_raddr;

   logic [mlwed_pkg::KEY_WIDTH-1:0] key_rdata;
   logic [W-1:0]      ct_rdata;
   logic [W-1:0]      acc;
   mlwed_pkg::mac_ctrl_type mac_ctrl;
   logic              mac_clear;

   logic [W-1:0]      phase, sum_word;
   logic              div_start, div_done, div_use_q;
   logic [W-1:0]      div_dividend, div_divisor, div_quotient, div_remainder;
   logic [PW-1:0]     red;

   logic               rsp_strobe_ff, rsp_strobe_in;
   mlwed_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mlwed_pkg::MODULUS_DEFAULT;
         delta_ff   <= mlwed_pkg::DELTA_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mlwed_pkg::CSR_PLAINTEXT_MODULUS: modulus_ff <= csr_data[PW-1:0];
            mlwed_pkg::CSR_SCALE_DELTA:       delta_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign p_eff = (modulus_ff == '0 || modulus_ff > mlwed_pkg::MODULUS_DEFAULT)
                  ? mlwed_pkg::MODULUS_DEFAULT : modulus_ff;
   assign delta_eff = (delta_ff == '0) ? W'(1) : delta_ff;

   // request decode
   assign pos_wide = {{(W - mlwed_pkg::POSITION_WIDTH){1'b0}}, req_data.position};
   assign accept   = start && !busy;
   assign key_we   = accept && req_data.mode == mlwed_pkg::MODE_LOAD_KEY
                     && pos_wide < W'(KEY_DEPTH);
   assign ct_we    = accept && req_data.mode == mlwed_pkg::MODE_LOAD_CIPHER
                     && pos_wide < W'(CT_DEPTH);
   assign read_go  = accept && req_data.mode == mlwed_pkg::MODE_READ
                     && pos_wide < W'(RING_DEGREE);

   // negacyclic address generation
   assign j_after_i = j_ff > i_ff;
   assign i_minus_j = {1'b0, i_ff} - {1'b0, j_ff};
   assign ct_idx    = j_after_i ? (i_minus_j[JW-1:0] + JW'(RING_DEGREE))
                                : i_minus_j[JW-1:0];
   assign ct_raddr  = issue ? (row_base_ff + CT_AW'(ct_idx))
                            : (CT_AW'(KEY_DEPTH) + CT_AW'(i_ff));

   mlwed_store #(
      .RING_DEGREE(RING_DEGREE),
      .MODULE_RANK(MODULE_RANK)
   ) u_store (
      .clock    (clock),
      .key_we   (key_we),
      .key_waddr(pos_wide[KEY_AW-1:0]),
      .key_wdata(req_data.key_coeff),
      .key_raddr(key_addr_ff),
      .key_rdata(key_rdata),
      .ct_we    (ct_we),
      .ct_waddr (pos_wide[CT_AW-1:0]),
      .ct_wdata (req_data.cipher_word),
      .ct_raddr (ct_raddr),
      .ct_rdata (ct_rdata)
   );

   assign mac_ctrl = '{clear: mac_clear, valid: rd_valid_ff, negate: rd_neg_ff};

   mlwed_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .key_word(key_rdata),
      .ct_word (ct_rdata),
      .acc     (acc)
   );

   // centred phase plus half delta, magnitude folded into one add
   assign phase    = ct_rdata - acc;
   assign sum_word = (delta_eff >> 1) + (phase[W-1] ? ~phase : phase)
                     + {{(W - 1){1'b0}}, phase[W-1]};

   assign div_dividend = div_use_q ? div_quotient : sum_word;
   assign div_divisor  = div_use_q ? {{(W - PW){1'b0}}, p_eff} : delta_eff;

   mlwed_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   assign red = div_remainder[PW-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      key_addr_in   = key_addr_ff;
      row_base_in   = row_base_ff;
      drain_in      = drain_ff;
      idx_in        = idx_ff;
      neg_in        = neg_ff;
      issue         = 1'b0;
      mac_clear     = 1'b0;
      div_start     = 1'b0;
      div_use_q     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         mlwed_pkg::ST_IDLE: begin
            if (read_go) begin
               i_in        = pos_wide[JW-1:0];
               idx_in      = req_data.position[mlwed_pkg::INDEX_WIDTH-1:0];
               j_in        = '0;
               key_addr_in = '0;
               row_base_in = '0;
               mac_clear   = 1'b1;
               state_in    = mlwed_pkg::ST_MAC;
            end
         end
         mlwed_pkg::ST_MAC: begin
            issue       = 1'b1;
            key_addr_in = key_addr_ff + 1'b1;
            if (j_ff == JW'(RING_DEGREE - 1)) begin
               j_in        = '0;
               row_base_in = row_base_ff + CT_AW'(RING_DEGREE);
            end else begin
               j_in = j_ff + 1'b1;
            end
            if (key_addr_ff == KEY_AW'(KEY_DEPTH - 1)) begin
               drain_in = 1'b0;
               state_in = mlwed_pkg::ST_DRAIN;
            end
         end
         mlwed_pkg::ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = mlwed_pkg::ST_ROUND;
            end
         end
         mlwed_pkg::ST_ROUND: begin
            neg_in    = phase[W-1];
            div_start = 1'b1;
            state_in  = mlwed_pkg::ST_QUOT;
         end
         mlwed_pkg::ST_QUOT: begin
            if (div_done) begin
               state_in = mlwed_pkg::ST_REM_START;
            end
         end
         mlwed_pkg::ST_REM_START: begin
            div_use_q = 1'b1;
            div_start = 1'b1;
            state_in  = mlwed_pkg::ST_REM;
         end
         mlwed_pkg::ST_REM: begin
            if (div_done) begin
               state_in = mlwed_pkg::ST_FINAL;
            end
         end
         mlwed_pkg::ST_FINAL: begin
            rsp_strobe_in             = 1'b1;
            rsp_data_in.coeff_index   = idx_ff;
            rsp_data_in.message_coeff = (neg_ff && red != '0)
                                        ? 16'(p_eff - red) : red[15:0];
            state_in                  = mlwed_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlwed_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mlwed_pkg::ST_IDLE;
         j_ff          <= '0;
         key_addr_ff   <= '0;
         row_base_ff   <= '0;
         drain_ff      <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rd_neg_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         j_ff          <= j_in;
         key_addr_ff   <= key_addr_in;
         row_base_ff   <= row_base_in;
         drain_ff      <= drain_in;
         rd_valid_ff   <= issue;
         rd_neg_ff     <= issue && j_after_i;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = state_ff != mlwed_pkg::ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   `ASSERT_NEXT(a_read_sets_busy, clock, reset, read_go, busy)
   `ASSERT_NEXT(a_final_gives_strobe, clock, reset, state_ff == mlwed_pkg::ST_FINAL, rsp_strobe && !busy)
   `ASSERT_IMPLY(a_strobe_after_final, clock, reset, rsp_strobe, $past(state_ff) == mlwed_pkg::ST_FINAL)
   `ASSERT_IMPLY(a_message_below_p, clock, reset, rsp_strobe, {1'b0, rsp_data.message_coeff} < p_eff)
   `ASSERT_IMPLY(a_no_mac_while_dividing, clock, reset, div_start, !rd_valid_ff && !issue)

endmodule

>>> sv/mlwed_store.sv
// ----------------------------------------------------------------------------
// mlwed_store
// secret key and ciphertext memories, one write and one registered read each
// ----------------------------------------------------------------------------
module mlwed_store #(
   parameter int RING_DEGREE = mlwed_pkg::RING_DEGREE_DEFAULT,
   parameter int MODULE_RANK = mlwed_pkg::MODULE_RANK_DEFAULT,
   localparam int KEY_DEPTH  = MODULE_RANK * RING_DEGREE,
   localparam int CT_DEPTH   = (MODULE_RANK + 1) * RING_DEGREE,
   localparam int KEY_AW     = $clog2(KEY_DEPTH),
   localparam int CT_AW      = $clog2(CT_DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 key_we,
   input  logic [KEY_AW-1:0]                    key_waddr,
   input  logic [mlwed_pkg::KEY_WIDTH-1:0]      key_wdata,
   input  logic [KEY_AW-1:0]                    key_raddr,
   output logic [mlwed_pkg::KEY_WIDTH-1:0]      key_rdata,
   input  logic                                 ct_we,
   input  logic [CT_AW-1:0]                     ct_waddr,
   input  logic [mlwed_pkg::WORD_WIDTH-1:0]     ct_wdata,
   input  logic [CT_AW-1:0]                     ct_raddr,
   output logic [mlwed_pkg::WORD_WIDTH-1:0]     ct_rdata
);

   logic [mlwed_pkg::KEY_WIDTH-1:0]  key_mem [KEY_DEPTH];
   logic [mlwed_pkg::WORD_WIDTH-1:0] ct_mem  [CT_DEPTH];
   logic [mlwed_pkg::KEY_WIDTH-1:0]  key_rdata_ff;
   logic [mlwed_pkg::WORD_WIDTH-1:0] ct_rdata_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rdata_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (ct_we) begin
         ct_mem[ct_waddr] <= ct_wdata;
      end
      ct_rdata_ff <= ct_mem[ct_raddr];
   end

   assign key_rdata = key_rdata_ff;
   assign ct_rdata  = ct_rdata_ff;

endmodule

>>> sv/mlwed_mac.sv
// ----------------------------------------------------------------------------
// mlwed_mac
// shared multiply-accumulate, products and sum modulo 2^32
// ----------------------------------------------------------------------------
module mlwed_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  mlwed_pkg::mac_ctrl_type            ctrl,
   input  logic [mlwed_pkg::KEY_WIDTH-1:0]    key_word,
   input  logic [mlwed_pkg::WORD_WIDTH-1:0]   ct_word,
   output logic [mlwed_pkg::WORD_WIDTH-1:0]   acc
);

   localparam int EXT_WIDTH = mlwed_pkg::WORD_WIDTH - mlwed_pkg::KEY_WIDTH;

   logic [mlwed_pkg::WORD_WIDTH-1:0] key_ext;
   logic [mlwed_pkg::WORD_WIDTH-1:0] prod_in, prod_ff;
   logic                             prod_valid_ff, prod_neg_ff;
   logic [mlwed_pkg::WORD_WIDTH-1:0] acc_in, acc_ff;

   assign key_ext = {{EXT_WIDTH{key_word[mlwed_pkg::KEY_WIDTH-1]}}, key_word};
   assign prod_in = ct_word * key_ext;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = prod_neg_ff ? (acc_ff - prod_ff) : (acc_ff + prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         prod_neg_ff   <= 1'b0;
         acc_ff        <= '0;
      end else begin
         prod_valid_ff <= ctrl.valid;
         prod_neg_ff   <= ctrl.negate;
         acc_ff        <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> sv/mlwed_divider.sv
// ----------------------------------------------------------------------------
// mlwed_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mlwed_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mlwed_pkg::WORD_WIDTH-1:0]   dividend,
   input  logic [mlwed_pkg::WORD_WIDTH-1:0]   divisor,
   output logic                               done,
   output logic [mlwed_pkg::WORD_WIDTH-1:0]   quotient,
   output logic [mlwed_pkg::WORD_WIDTH-1:0]   remainder
);

   localparam int W  = mlwed_pkg::WORD_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          running_ff, running_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted, trial;

   always_comb begin
      shifted    = {rem_ff, quo_ff[W-1]};
      trial      = shifted - {1'b0, dsr_ff};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         cnt_in     = CW'(W);
         running_in = 1'b1;
      end else if (running_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
         end else begin
            rem_in = shifted[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], !trial[W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
